// ----- design/swi_pkg.sv -----
`timescale 1ns / 1ps
// Shared widths, division constants and lookup tables for the wake interval block.
// No dependencies; imported by every module of the block.
package swi_pkg;

   // Port and field widths
   localparam int TIME_W      = 32;
   localparam int RESULT_W    = 17;
   localparam int REQ_TDATA_W = 32;
   localparam int RSP_TDATA_W = 24;

   // Internal value widths
   localparam int DAYS_W  = 16;   // day number, at most 49710
   localparam int SOD_W   = 17;   // second of the day, below 86400
   localparam int DOE_W   = 18;   // day of 400-year era, up to 146096
   localparam int YOE_W   = 9;    // year of era, up to 399
   localparam int DOY_W   = 9;    // day of March-based year, up to 365
   localparam int MON_W   = 4;
   localparam int MDAY_W  = 5;
   localparam int TENTH_W = 19;   // sunrise table entries in tenths of a second
   localparam int BLEND_W = 24;   // blended sunrise, tenths times 31
   localparam int SUN_W   = 15;   // sunrise in whole seconds

   // Seconds to days: now / 86400 == (now >> 7) / 675
   localparam logic [9:0]  DAY_DIV7 = 10'd675;
   localparam logic [15:0] DAY_RCP  = 16'((1 << 25) / 675);

   // Day number to era and day of era
   localparam logic [15:0] ERA5_DAY = 16'd11017;    // first day of era 5 (2000-03-01)
   localparam logic [17:0] ERA4_OFS = 18'd135080;   // days + 719468 - 4 * 146097
   localparam logic [17:0] CENT1    = 18'd36524;
   localparam logic [17:0] CENT2    = 18'd73048;
   localparam logic [17:0] CENT3    = 18'd109572;

   // Leap-cycle and year divisions
   localparam logic [10:0] QUAD_DIV = 11'd1460;
   localparam logic [7:0]  QUAD_RCP = 8'((1 << 18) / 1460);
   localparam logic [8:0]  YEAR_DIV = 9'd365;
   localparam logic [9:0]  YEAR_RCP = 10'((1 << 18) / 365);

   // Sunrise blend and target
   localparam logic [8:0]  BLEND_DIV = 9'd310;
   localparam logic [15:0] BLEND_RCP = 16'((1 << 24) / 310);
   localparam logic [16:0] WAKE_OFS  = 17'd7200;
   localparam logic [16:0] DAY_SECS  = 17'd86400;
   localparam logic [4:0]  MDAY_MAX  = 5'd31;
   localparam logic [3:0]  MON_LAST  = 4'd11;

   // First day of each month in a year that starts on March 1
   function automatic logic [DOY_W-1:0] month_start(input logic [MON_W-1:0] mp);
      logic [DOY_W-1:0] s;
      case (mp)
         4'd0:    s = 9'd0;
         4'd1:    s = 9'd31;
         4'd2:    s = 9'd61;
         4'd3:    s = 9'd92;
         4'd4:    s = 9'd122;
         4'd5:    s = 9'd153;
         4'd6:    s = 9'd184;
         4'd7:    s = 9'd214;
         4'd8:    s = 9'd245;
         4'd9:    s = 9'd275;
         4'd10:   s = 9'd306;
         4'd11:   s = 9'd337;
         default: s = 9'd0;
      endcase
      return s;
   endfunction

   // Sunrise per month (January first), tenths of a second after midnight UTC
   function automatic logic [TENTH_W-1:0] sunrise_tenths(input logic [MON_W-1:0] mi);
      logic [TENTH_W-1:0] t;
      case (mi)
         4'd0:    t = 19'd316800;
         4'd1:    t = 19'd301212;
         4'd2:    t = 19'd270000;
         4'd3:    t = 19'd228600;
         4'd4:    t = 19'd191412;
         4'd5:    t = 19'd166212;
         4'd6:    t = 19'd164988;
         4'd7:    t = 19'd186588;
         4'd8:    t = 19'd215388;
         4'd9:    t = 19'd243000;
         4'd10:   t = 19'd274212;
         4'd11:   t = 19'd303588;
         default: t = 19'd0;
      endcase
      return t;
   endfunction

endpackage

// ----- design/swi_day_split.sv -----
`timescale 1ns / 1ps
// Three-stage split of a Unix time into day number and second of the day.
// Depends on swi_pkg.
module swi_day_split (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        en,
   input  logic                        in_valid,
   input  logic [swi_pkg::TIME_W-1:0]  now,
   output logic                        out_valid,
   output logic [swi_pkg::DAYS_W-1:0]  days,
   output logic [swi_pkg::SOD_W-1:0]   sod
);
   import swi_pkg::*;

   localparam int X_W = TIME_W - 7;

   logic [2:0]          valid_ff;
   logic [2:0]          valid_in;

   logic [X_W-1:0]      x1_ff, x1_in;
   logic [6:0]          low1_ff, low2_ff;
   logic [DAYS_W-1:0]   qe1_ff, qe1_in, qe2_ff;
   logic [10:0]         rem2_ff, rem2_in;
   logic [DAYS_W-1:0]   days3_ff, days3_in;
   logic [SOD_W-1:0]    sod3_ff, sod3_in;

   logic [X_W+15:0]     rcp_prod;
   logic [X_W-1:0]      qd_mul;
   logic [10:0]         rem_sub;

   assign valid_in = {valid_ff[1:0], in_valid};

   // Stage 1: estimate (now >> 7) / 675 by reciprocal, low by at most one
   assign x1_in    = now[TIME_W-1:7];
   assign rcp_prod = (X_W + 16)'(x1_in) * (X_W + 16)'(DAY_RCP);
   assign qe1_in   = rcp_prod[X_W+15:X_W];

   // Stage 2: remainder of the estimate, below twice the divisor
   assign qd_mul  = X_W'(qe1_ff) * X_W'(DAY_DIV7);
   assign rem2_in = 11'(x1_ff - qd_mul);

   // Stage 3: one correction step, rebuild the second of the day
   assign rem_sub = rem2_ff - 11'(DAY_DIV7);
   always_comb begin
      if (rem2_ff >= 11'(DAY_DIV7)) begin
         days3_in = qe2_ff + 16'd1;
         sod3_in  = {rem_sub[9:0], low2_ff};
      end else begin
         days3_in = qe2_ff;
         sod3_in  = {rem2_ff[9:0], low2_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x1_ff    <= x1_in;
         low1_ff  <= now[6:0];
         qe1_ff   <= qe1_in;
         rem2_ff  <= rem2_in;
         qe2_ff   <= qe1_ff;
         low2_ff  <= low1_ff;
         days3_ff <= days3_in;
         sod3_ff  <= sod3_in;
      end
   end

   assign out_valid = valid_ff[2];
   assign days      = days3_ff;
   assign sod       = sod3_ff;

endmodule

// ----- design/swi_calendar.sv -----
`timescale 1ns / 1ps
// Eight-stage Gregorian conversion of a day number to month index and day of month.
// Depends on swi_pkg; carries the second of the day alongside.
module swi_calendar (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        en,
   input  logic                        in_valid,
   input  logic [swi_pkg::DAYS_W-1:0]  days,
   input  logic [swi_pkg::SOD_W-1:0]   sod_i,
   output logic                        out_valid,
   output logic [swi_pkg::MON_W-1:0]   mon_idx,
   output logic [swi_pkg::MDAY_W-1:0]  mday,
   output logic [swi_pkg::SOD_W-1:0]   sod_o
);
   import swi_pkg::*;

   localparam int DEPTH = 8;

   logic [DEPTH-1:0]    valid_ff;
   logic [SOD_W-1:0]    sod_ff [DEPTH];

   // Day of era travels through stages 1 to 5
   logic [DOE_W-1:0]    doe_ff [5];
   logic [DOE_W-1:0]    doe1_in;

   logic [6:0]          pe2_ff, pe2_in;
   logic [1:0]          cnt2_ff, cnt2_in;
   logic [25:0]         quad_prod;

   logic [DOE_W-1:0]    n3_ff, n3_in, n4_ff;
   logic [DOE_W-1:0]    quad_rem;
   logic [6:0]          p_fix;

   logic [YOE_W-1:0]    ye4_ff, ye4_in;
   logic [27:0]         year_prod;

   logic [YOE_W-1:0]    yoe5_ff, yoe5_in;
   logic [DOE_W-1:0]    year_rem;

   logic [DOY_W-1:0]    doy6_ff, doy6_in, doy7_ff;
   logic [1:0]          ycnt;
   logic [DOE_W-1:0]    doy_full;

   logic [MON_W-1:0]    mp7_ff, mp7_in;
   logic [MON_W-1:0]    mon8_ff, mon8_in;
   logic [MDAY_W-1:0]   mday8_ff, mday8_in;
   logic [DOY_W-1:0]    doy_ofs;

   // Stage 1: day of the 400-year era (only eras 4 and 5 occur)
   assign doe1_in = (days >= ERA5_DAY) ? DOE_W'(days - ERA5_DAY)
                                       : DOE_W'(days) + ERA4_OFS;

   // Stage 2: leap-cycle count estimate and century count
   assign quad_prod = 26'(doe_ff[0]) * 26'(QUAD_RCP);
   assign pe2_in    = quad_prod[24:18];
   assign cnt2_in   = 2'(doe_ff[0] >= CENT1) + 2'(doe_ff[0] >= CENT2)
                    + 2'(doe_ff[0] >= CENT3);

   // Stage 3: correct the leap-cycle count, form the year-aligned day count
   assign quad_rem = doe_ff[1] - DOE_W'(pe2_ff) * DOE_W'(QUAD_DIV);
   assign p_fix    = (quad_rem >= DOE_W'(QUAD_DIV)) ? pe2_ff + 7'd1 : pe2_ff;
   assign n3_in    = doe_ff[1] - DOE_W'(p_fix) + DOE_W'(cnt2_ff);

   // Stage 4: year of era estimate
   assign year_prod = 28'(n3_ff) * 28'(YEAR_RCP);
   assign ye4_in    = year_prod[26:18];

   // Stage 5: year of era correction
   assign year_rem = n4_ff - DOE_W'(ye4_ff) * DOE_W'(YEAR_DIV);
   assign yoe5_in  = (year_rem >= DOE_W'(YEAR_DIV)) ? ye4_ff + 9'd1 : ye4_ff;

   // Stage 6: day of the March-based year
   assign ycnt     = 2'(yoe5_ff >= 9'd100) + 2'(yoe5_ff >= 9'd200)
                   + 2'(yoe5_ff >= 9'd300);
   assign doy_full = doe_ff[4] - DOE_W'(yoe5_ff) * DOE_W'(YEAR_DIV)
                   - DOE_W'(yoe5_ff >> 2) + DOE_W'(ycnt);
   assign doy6_in  = doy_full[DOY_W-1:0];

   // Stage 7: month of the March-based year by threshold count
   always_comb begin
      mp7_in = '0;
      for (int i = 1; i < 12; i++) begin
         mp7_in = mp7_in + MON_W'(doy6_ff >= month_start(MON_W'(i)));
      end
   end

   // Stage 8: day of month and January-based month index
   assign doy_ofs  = doy7_ff - month_start(mp7_ff);
   assign mday8_in = MDAY_W'(doy_ofs) + 5'd1;
   assign mon8_in  = (mp7_ff < 4'd10) ? mp7_ff + 4'd2 : mp7_ff - 4'd10;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[DEPTH-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sod_ff[0] <= sod_i;
         for (int i = 1; i < DEPTH; i++) begin
            sod_ff[i] <= sod_ff[i-1];
         end
         doe_ff[0] <= doe1_in;
         for (int i = 1; i < 5; i++) begin
            doe_ff[i] <= doe_ff[i-1];
         end
         pe2_ff   <= pe2_in;
         cnt2_ff  <= cnt2_in;
         n3_ff    <= n3_in;
         n4_ff    <= n3_ff;
         ye4_ff   <= ye4_in;
         yoe5_ff  <= yoe5_in;
         doy6_ff  <= doy6_in;
         doy7_ff  <= doy6_ff;
         mp7_ff   <= mp7_in;
         mon8_ff  <= mon8_in;
         mday8_ff <= mday8_in;
      end
   end

   assign out_valid = valid_ff[DEPTH-1];
   assign mon_idx   = mon8_ff;
   assign mday      = mday8_ff;
   assign sod_o     = sod_ff[DEPTH-1];

   // Calendar outputs stay within their ranges
   a_mday_range: assert property (@(posedge clock) disable iff (reset)
      out_valid |-> (mday != 5'd0) && (mday <= MDAY_MAX))
      else $error("day of month out of range");

   a_mon_range: assert property (@(posedge clock) disable iff (reset)
      out_valid |-> (mon_idx <= MON_LAST))
      else $error("month index out of range");

   a_doy_range: assert property (@(posedge clock) disable iff (reset)
      valid_ff[5] |-> (doy6_ff <= 9'd365))
      else $error("day of year out of range");

endmodule

// ----- design/swi_interval.sv -----
`timescale 1ns / 1ps
// Five-stage sunrise blend, wake target and interval from the present second.
// Depends on swi_pkg (sunrise table and division constants).
module swi_interval (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          en,
   input  logic                          in_valid,
   input  logic [swi_pkg::MON_W-1:0]     mon_idx,
   input  logic [swi_pkg::MDAY_W-1:0]    mday,
   input  logic [swi_pkg::SOD_W-1:0]     sod,
   output logic                          out_valid,
   output logic [swi_pkg::RESULT_W-1:0]  result
);
   import swi_pkg::*;

   localparam int DEPTH = 5;

   logic [DEPTH-1:0]     valid_ff;
   logic [SOD_W-1:0]     sod_ff [DEPTH-1];

   logic [MON_W-1:0]     mon_next;
   logic [BLEND_W-1:0]   pa1_ff, pa1_in, pb1_ff, pb1_in;
   logic [BLEND_W-1:0]   blend2_ff, blend2_in, blend3_ff;
   logic [39:0]          sun_prod;
   logic [SUN_W-1:0]     se3_ff, se3_in;
   logic [BLEND_W-1:0]   sun_rem;
   logic [SUN_W-1:0]     sun_fix;
   logic [RESULT_W-1:0]  target4_ff, target4_in;
   logic [RESULT_W-1:0]  result5_ff, result5_in;

   // Stage 1: weigh this month's and next month's sunrise by day of month
   assign mon_next = (mon_idx == MON_LAST) ? 4'd0 : mon_idx + 4'd1;
   assign pa1_in   = BLEND_W'(sunrise_tenths(mon_idx)) * BLEND_W'(MDAY_MAX - mday);
   assign pb1_in   = BLEND_W'(sunrise_tenths(mon_next)) * BLEND_W'(mday);

   // Stage 2: blended sunrise in tenths times 31
   assign blend2_in = pa1_ff + pb1_ff;

   // Stage 3: estimate blend / 310
   assign sun_prod = 40'(blend2_ff) * 40'(BLEND_RCP);
   assign se3_in   = sun_prod[38:24];

   // Stage 4: correct to whole seconds, add the wake offset
   assign sun_rem    = blend3_ff - BLEND_W'(se3_ff) * BLEND_W'(BLEND_DIV);
   assign sun_fix    = (sun_rem >= BLEND_W'(BLEND_DIV)) ? se3_ff + 15'd1 : se3_ff;
   assign target4_in = RESULT_W'(sun_fix) + WAKE_OFS;

   // Stage 5: today if still ahead, otherwise tomorrow
   assign result5_in = (target4_ff > sod_ff[3]) ? target4_ff - sod_ff[3]
                                                : target4_ff + DAY_SECS - sod_ff[3];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[DEPTH-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sod_ff[0] <= sod;
         for (int i = 1; i < DEPTH - 1; i++) begin
            sod_ff[i] <= sod_ff[i-1];
         end
         pa1_ff     <= pa1_in;
         pb1_ff     <= pb1_in;
         blend2_ff  <= blend2_in;
         blend3_ff  <= blend2_ff;
         se3_ff     <= se3_in;
         target4_ff <= target4_in;
         result5_ff <= result5_in;
      end
   end

   assign out_valid = valid_ff[DEPTH-1];
   assign result    = result5_ff;

endmodule

// ----- design/sunrise_wake_interval_top.sv -----
`timescale 1ns / 1ps
// Top level of the wake interval block: pipeline stages and output buffer.
// Depends on swi_pkg, swi_day_split, swi_calendar and swi_interval.
//
// Usage:
//   req_* carries one present time (Unix seconds, UTC) per transfer; rsp_*
//   returns one interval per request, in order: seconds from that time to
//   two hours after the month-blended sunrise, today or else tomorrow
//   (1 to 86400).
//   Throughput is one transfer per cycle while req_tready is high. From the
//   accepting edge to rsp_tvalid, 3 stages split days from seconds, 8 stages
//   do the calendar conversion, 5 stages blend the sunrise and form the
//   interval, and one output register presents the result.
//   The output register has a one-entry skid buffer behind it. When the
//   receiver holds rsp_tready low, the next result goes into the skid entry
//   and the whole pipeline then freezes with req_tready low; nothing is
//   dropped or repeated. req_tready depends only on the skid entry.
//   Reset (synchronous, active high) clears all valid bits; the block takes
//   a request in the first cycle after reset is released.
module sunrise_wake_interval_top (
   input  logic                             clock,
   input  logic                             reset,
   // req_tdata: [31:0] current_time
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [swi_pkg::REQ_TDATA_W-1:0]  req_tdata,
   // rsp_tdata: [16:0] seconds_until_sample, [23:17] zero
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [swi_pkg::RSP_TDATA_W-1:0]  rsp_tdata
);
   import swi_pkg::*;

   logic                  en;
   logic                  split_valid, cal_valid, int_valid;
   logic [DAYS_W-1:0]     split_days;
   logic [SOD_W-1:0]      split_sod, cal_sod;
   logic [MON_W-1:0]      cal_mon;
   logic [MDAY_W-1:0]     cal_mday;
   logic [RESULT_W-1:0]   int_result;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RESULT_W-1:0]   rsp_data_ff, rsp_data_in;
   logic                  skid_valid_ff, skid_valid_in;
   logic [RESULT_W-1:0]   skid_data_ff, skid_data_in;
   logic                  out_free;

   // Pipeline advances whenever the skid entry is empty
   assign en         = ~skid_valid_ff;
   assign req_tready = en;

   swi_day_split u_split (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_tvalid),
      .now       (req_tdata[TIME_W-1:0]),
      .out_valid (split_valid),
      .days      (split_days),
      .sod       (split_sod)
   );

   swi_calendar u_cal (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (split_valid),
      .days      (split_days),
      .sod_i     (split_sod),
      .out_valid (cal_valid),
      .mon_idx   (cal_mon),
      .mday      (cal_mday),
      .sod_o     (cal_sod)
   );

   swi_interval u_int (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (cal_valid),
      .mon_idx   (cal_mon),
      .mday      (cal_mday),
      .sod       (cal_sod),
      .out_valid (int_valid),
      .result    (int_result)
   );

   // Output register plus skid entry
   assign out_free = ~rsp_valid_ff | rsp_tready;

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (skid_valid_ff) begin
         if (rsp_tready) begin
            rsp_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (int_valid) begin
         if (out_free) begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = int_result;
         end else begin
            skid_valid_in = 1'b1;
            skid_data_in  = int_result;
         end
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff  <= rsp_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_TDATA_W'(rsp_data_ff);

   // Skid entry only fills behind a held result
   a_skid_behind_rsp: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid entry valid without output register valid");

   // Draining the skid entry moves its value into the output register
   a_skid_drain: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff && rsp_tready |=> rsp_valid_ff && !skid_valid_ff
                                      && (rsp_data_ff == $past(skid_data_ff)))
      else $error("skid entry lost on drain");

   // Every interval lies within one day
   a_result_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff != '0) && (rsp_data_ff <= DAY_SECS))
      else $error("interval out of range");

endmodule
